/* sv/fsgs_pkg.sv */
// ----------------------------------------------------------------------------
// fsgs_pkg
// Shared types and constants for the falling sand grid step block.
// ----------------------------------------------------------------------------
`default_nettype none

package fsgs_pkg;

   localparam int GRID_SIDE_DEF = 32;

   localparam logic [31:0] EMPTY_COLOR = 32'h0000_00FF;
   localparam logic [31:0] LFSR_TAPS   = 32'h8020_0003;
   localparam logic [2:0]  KIND_EMPTY  = 3'd0;
   localparam logic [2:0]  KIND_MAX    = 3'd4;

   localparam logic [1:0] OP_PLACE = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_WRITE
   } state_type;

   typedef enum logic [1:0] {
      MOVE_NONE,
      MOVE_DOWN,
      MOVE_LEFT,
      MOVE_RIGHT
   } move_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] color;
   } cell_type;

   typedef struct packed {
      cell_type contents;
      move_type move;
   } slot_type;

   typedef struct packed {
      logic valid;
      logic row_last;
      logic col_first;
      logic col_last;
      logic choice_bit;
   } rule_ctl_type;

endpackage

`default_nettype wire

/* sv/fsgs_cell.sv */
// ----------------------------------------------------------------------------
// fsgs_cell
// One stage of the scan chain: holds an old grid cell and its move code.
// ----------------------------------------------------------------------------
`default_nettype none

module fsgs_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear,
   input  wire logic              shift,
   input  wire fsgs_pkg::slot_type d,
   output fsgs_pkg::slot_type      q
);
   import fsgs_pkg::*;

   cell_type cell_ff;
   move_type move_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         move_ff <= MOVE_NONE;
      end else if (shift) begin
         move_ff <= d.move;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         cell_ff <= d.contents;
      end
   end

   assign q = '{contents: cell_ff, move: move_ff};

endmodule

`default_nettype wire

/* sv/fsgs_rule.sv */
// ----------------------------------------------------------------------------
// fsgs_rule
// Move decision for the current cell and the new value written back for it.
// ----------------------------------------------------------------------------
`default_nettype none

module fsgs_rule (
   input  wire fsgs_pkg::rule_ctl_type ctl,
   input  wire fsgs_pkg::cell_type     self_cell,
   input  wire logic [2:0]             below_kind,
   input  wire logic [2:0]             below_left_kind,
   input  wire logic [2:0]             below_right_kind,
   input  wire fsgs_pkg::slot_type     up_left,
   input  wire fsgs_pkg::slot_type     up,
   input  wire fsgs_pkg::slot_type     up_right,
   output fsgs_pkg::move_type          move,
   output logic                        use_bit,
   output fsgs_pkg::cell_type          new_cell
);
   import fsgs_pkg::*;

   logic left_free;
   logic right_free;

   always_comb begin
      left_free  = !ctl.col_first && (below_left_kind == KIND_EMPTY);
      right_free = !ctl.col_last && (below_right_kind == KIND_EMPTY);
      move    = MOVE_NONE;
      use_bit = 1'b0;
      if (ctl.valid && (self_cell.kind != KIND_EMPTY) && !ctl.row_last) begin
         if (below_kind == KIND_EMPTY) begin
            move = MOVE_DOWN;
         end else if (left_free && right_free) begin
            use_bit = 1'b1;
            move    = ctl.choice_bit ? MOVE_LEFT : MOVE_RIGHT;
         end else if (left_free) begin
            move = MOVE_LEFT;
         end else if (right_free) begin
            move = MOVE_RIGHT;
         end
      end

      // last writer in scan order wins
      if (self_cell.kind != KIND_EMPTY) begin
         if (move != MOVE_NONE) begin
            new_cell = '{kind: KIND_EMPTY, color: EMPTY_COLOR};
         end else begin
            new_cell = self_cell;
         end
      end else if (up_right.move == MOVE_LEFT) begin
         new_cell = up_right.contents;
      end else if (up.move == MOVE_DOWN) begin
         new_cell = up.contents;
      end else if (up_left.move == MOVE_RIGHT) begin
         new_cell = up_left.contents;
      end else begin
         new_cell = self_cell;
      end
   end

endmodule

`default_nettype wire

/* sv/falling_sand_grid_step.sv */
// ----------------------------------------------------------------------------
// falling_sand_grid_step
// Falling sand grid of GRID_SIDE x GRID_SIDE cells with place, read and tick.
// ----------------------------------------------------------------------------
// After reset the block sweeps the grid memory clear, one cell a cycle, with
// busy high. A place, a read or an undefined op is taken while idle and its
// word appears on rsp_ the next cycle, with busy low so another item may
// follow at once. A tick streams the old grid through a chain of
// 2*GRID_SIDE+2 cells and writes each new cell back in place; the
// single-port grid memory takes one read and one write per cell, in turn
// in ST_READ and ST_WRITE.
// rsp_valid is a one-cycle strobe that the receiver cannot hold off.
`default_nettype none

module falling_sand_grid_step #(
   parameter int GRID_SIDE = fsgs_pkg::GRID_SIDE_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_op,
   input  wire logic [4:0]  req_row,
   input  wire logic [4:0]  req_col,
   input  wire logic [31:0] req_grain_color,
   input  wire logic [2:0]  req_grain_kind,
   output logic             rsp_valid,
   output logic [31:0]      rsp_cell_color,
   output logic [2:0]       rsp_cell_kind,
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata
);
   import fsgs_pkg::*;

   localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
   localparam int SIDE_W     = $clog2(GRID_SIDE);
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int SCAN_W     = $clog2(CELL_COUNT + GRID_SIDE + 1);
   localparam int CHAIN_N    = 2 * GRID_SIDE + 2;

   state_type state_ff, state_in;
   cell_type  grid_mem [CELL_COUNT];
   cell_type  grid_rdata_ff;
   logic [ADDR_W-1:0] mem_addr;
   logic              mem_we;
   cell_type          mem_wdata;

   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic [ADDR_W-1:0] q_addr_ff, q_addr_in;
   logic [SIDE_W-1:0] q_row_ff, q_row_in, q_col_ff, q_col_in;
   logic [31:0]       lfsr_ff, lfsr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_read_ff, rsp_read_in;

   logic              accept, in_grid, q_valid, chain_clear, chain_shift;
   logic [ADDR_W-1:0] req_addr;
   slot_type          chain_q [CHAIN_N];
   slot_type          chain_d [CHAIN_N];
   rule_ctl_type      ctl;
   move_type          rule_move;
   logic              rule_use_bit;
   cell_type          rule_cell;

   assign accept  = start && !busy;
   assign in_grid = (32'(req_row) < 32'(GRID_SIDE)) && (32'(req_col) < 32'(GRID_SIDE));
   assign req_addr = ADDR_W'(32'(req_row) * 32'(GRID_SIDE) + 32'(req_col));
   assign q_valid = scan_ff >= SCAN_W'(GRID_SIDE + 1);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_addr] <= mem_wdata;
      end
      grid_rdata_ff <= grid_mem[mem_addr];
   end

   assign ctl = '{valid:      q_valid,
                  row_last:   q_row_ff == SIDE_W'(GRID_SIDE - 1),
                  col_first:  q_col_ff == '0,
                  col_last:   q_col_ff == SIDE_W'(GRID_SIDE - 1),
                  choice_bit: lfsr_ff[0]};

   fsgs_rule u_rule (
      .ctl              (ctl),
      .self_cell        (chain_q[GRID_SIDE].contents),
      .below_kind       (chain_q[0].contents.kind),
      .below_left_kind  (chain_q[1].contents.kind),
      .below_right_kind (grid_rdata_ff.kind),
      .up_left          (chain_q[2*GRID_SIDE+1]),
      .up               (chain_q[2*GRID_SIDE]),
      .up_right         (chain_q[2*GRID_SIDE-1]),
      .move             (rule_move),
      .use_bit          (rule_use_bit),
      .new_cell         (rule_cell)
   );

   always_comb begin
      chain_d[0] = '{contents: grid_rdata_ff, move: MOVE_NONE};
      for (int k = 1; k < CHAIN_N; k++) begin
         chain_d[k] = chain_q[k-1];
      end
      chain_d[GRID_SIDE+1] = '{contents: chain_q[GRID_SIDE].contents, move: rule_move};
   end

   for (genvar k = 0; k < CHAIN_N; k++) begin : g_chain
      fsgs_cell u_cell (
         .clock (clock),
         .reset (reset),
         .clear (chain_clear),
         .shift (chain_shift),
         .d     (chain_d[k]),
         .q     (chain_q[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         scan_ff      <= '0;
         q_addr_ff    <= '0;
         q_row_ff     <= '0;
         q_col_ff     <= '0;
         lfsr_ff      <= 32'h1;
         rsp_valid_ff <= 1'b0;
         rsp_read_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         scan_ff      <= scan_in;
         q_addr_ff    <= q_addr_in;
         q_row_ff     <= q_row_in;
         q_col_ff     <= q_col_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_read_ff  <= rsp_read_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      scan_in      = scan_ff;
      q_addr_in    = q_addr_ff;
      q_row_in     = q_row_ff;
      q_col_in     = q_col_ff;
      lfsr_in      = lfsr_ff;
      rsp_valid_in = 1'b0;
      rsp_read_in  = 1'b0;
      mem_addr     = req_addr;
      mem_we       = 1'b0;
      mem_wdata    = '{kind: req_grain_kind, color: req_grain_color};
      chain_clear  = 1'b0;
      chain_shift  = 1'b0;
      busy         = 1'b1;

      case (state_ff)
         ST_CLEAR: begin
            mem_addr  = clr_ff;
            mem_we    = 1'b1;
            mem_wdata = '{kind: KIND_EMPTY, color: EMPTY_COLOR};
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (accept) begin
               rsp_valid_in = req_op != OP_TICK;
               rsp_read_in  = (req_op == OP_READ) && in_grid;
               mem_we       = (req_op == OP_PLACE) && in_grid && (req_grain_kind <= KIND_MAX);
               if (req_op == OP_TICK) begin
                  state_in    = ST_READ;
                  chain_clear = 1'b1;
                  scan_in     = '0;
                  q_addr_in   = '0;
                  q_row_in    = '0;
                  q_col_in    = '0;
               end
            end
         end
         ST_READ: begin
            mem_addr = scan_ff[ADDR_W-1:0];
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            mem_addr    = q_addr_ff;
            mem_we      = q_valid;
            mem_wdata   = rule_cell;
            chain_shift = 1'b1;
            scan_in     = scan_ff + 1'b1;
            state_in    = ST_READ;
            if (rule_use_bit) begin
               lfsr_in = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_TAPS : 32'h0);
            end
            if (q_valid) begin
               q_addr_in = q_addr_ff + 1'b1;
               if (q_col_ff == SIDE_W'(GRID_SIDE - 1)) begin
                  q_col_in = '0;
                  q_row_in = q_row_ff + 1'b1;
               end else begin
                  q_col_in = q_col_ff + 1'b1;
               end
            end
            if (scan_ff == SCAN_W'(CELL_COUNT + GRID_SIDE)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (csr_we) begin
         lfsr_in = (csr_wdata == 32'h0) ? 32'h1 : csr_wdata;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_color = rsp_read_ff ? grid_rdata_ff.color : 32'h0;
   assign rsp_cell_kind  = rsp_read_ff ? grid_rdata_ff.kind : KIND_EMPTY;

   a_lfsr_nonzero : assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != 32'h0) else $error("lfsr reached zero");

   a_no_word_in_clear : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff) else $error("word during clear");

   a_tick_starts : assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_TICK) |=> (state_ff == ST_READ && !rsp_valid_ff))
      else $error("tick did not start");

   a_read_word : assert property (@(posedge clock) disable iff (reset)
      rsp_read_ff |-> rsp_valid_ff) else $error("read data without word");

endmodule

`default_nettype wire
